>>> design/led_notify_fade_envelope_defines.svh
// Assertion macros shared by the checker of the LED fade envelope block.
// The macros expect signals named clk and rst_n in the scope that uses them.
`ifndef LED_NOTIFY_FADE_ENVELOPE_DEFINES_SVH
`define LED_NOTIFY_FADE_ENVELOPE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LNFE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("led envelope check failed");

// The consequent must hold in the cycle after the antecedent.
`define LNFE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("led envelope check failed");

`endif

>>> design/led_nfe_pkg.sv
// Package for the LED fade envelope block: request codes, defaults and types.
// Used by the front, back and top-level modules.
package led_nfe_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_NOTIFY = 2'd1;
    localparam logic [1:0] OP_WEAK   = 2'd2;

    localparam logic [1:0] REG_MAX  = 2'd0;
    localparam logic [1:0] REG_MIN  = 2'd1;
    localparam logic [1:0] REG_STEP = 2'd2;

    localparam logic [7:0] DEFAULT_HOLD = 8'd3;
    localparam logic [7:0] MAX_RESET    = 8'd10;
    localparam logic [7:0] MIN_RESET    = 8'd0;
    localparam logic [7:0] STEP_RESET   = 8'd2;
    localparam logic [7:0] FULL_SCALE   = 8'd255;
    // Smallest product whose quotient by 255 exceeds 255.
    localparam logic [23:0] SAT_LIMIT   = 24'd65280;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] hold;
    } cmd_t;

    // Divides a colour-times-level-squared product by 255 and saturates at 255.
    function automatic logic [7:0] drive_from_product(input logic [23:0] p);
        logic [16:0] t;
        begin
            t = {1'b0, p[15:0]} + {9'd0, p[15:8]} + 17'd1;
            if (p >= SAT_LIMIT)
            begin
                return FULL_SCALE;
            end
            return t[15:8];
        end
    endfunction

endpackage

>>> design/led_notify_fade_envelope.sv
// A lit tick is queued in the front end, then passes the back end's square, scale and
// drive steps before its result is registered; a dark or final tick gets its result from idle.
// The back end takes no new command until a lit tick leaves the drive step, as the steps
// share one envelope state; notifies go at one per cycle while the back end is idle.
// Reset (rst_n, asynchronous): envelope dark, colour zero, hold length three,
// registers max_level 10, min_level 0, step_size 2, command queue empty.
module led_notify_fade_envelope
    import led_nfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // red, green, blue, hold_ticks, hold_given, zero pad
    input  logic [1:0]  s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // red_drive, green_drive, blue_drive, lit, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_pop;
    logic [7:0] red_drive;
    logic [7:0] green_drive;
    logic [7:0] blue_drive;
    logic       lit;

    led_nfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .operation  (s_axis_tuser),
        .red        (s_axis_tdata[7:0]),
        .green      (s_axis_tdata[15:8]),
        .blue       (s_axis_tdata[23:16]),
        .hold_ticks (s_axis_tdata[31:24]),
        .hold_given (s_axis_tdata[32]),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop)
    );

    led_nfe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .red_drive   (red_drive),
        .green_drive (green_drive),
        .blue_drive  (blue_drive),
        .lit         (lit)
    );

    assign m_axis_tdata = {7'd0, lit, blue_drive, green_drive, red_drive};

endmodule

>>> design/led_nfe_front.sv
// Front end of the LED fade envelope block: accepts requests, drops unused
// codes, resolves the hold length and queues commands. Depends on led_nfe_pkg.
module led_nfe_front
    import led_nfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  hold_ticks,
    input  logic        hold_given,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    assign in_ready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_cmd.op    = operation;
        new_cmd.red   = red;
        new_cmd.green = green;
        new_cmd.blue  = blue;
        new_cmd.hold  = hold_given ? hold_ticks : DEFAULT_HOLD;
        push = in_valid && in_ready && (operation inside {OP_TICK, OP_NOTIFY, OP_WEAK});
        pop  = cmd_pop && cmd_valid;
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

>>> design/led_nfe_back.sv
// Back end of the LED fade envelope block: holds the envelope state and the
// configuration, advances the envelope and scales the colour. Uses led_nfe_pkg.
module led_nfe_back
    import led_nfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red_drive,
    output logic [7:0]  green_drive,
    output logic [7:0]  blue_drive,
    output logic        lit
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUARE = 2'd1;
    localparam logic [1:0] ST_SCALE  = 2'd2;
    localparam logic [1:0] ST_DRIVE  = 2'd3;

    logic [7:0]  max_reg;
    logic [7:0]  min_reg;
    logic [7:0]  step_reg;

    logic [1:0]  state_reg,     state_next;
    logic [7:0]  level_reg,     level_next;
    logic        rising_reg,    rising_next;
    logic        active_reg,    active_next;
    logic [7:0]  hold_left_reg, hold_left_next;
    logic [7:0]  hold_len_reg,  hold_len_next;
    logic [7:0]  col_r_reg,     col_r_next;
    logic [7:0]  col_g_reg,     col_g_next;
    logic [7:0]  col_b_reg,     col_b_next;
    logic [15:0] sq_reg,        sq_next;
    logic [23:0] prod_r_reg,    prod_r_next;
    logic [23:0] prod_g_reg,    prod_g_next;
    logic [23:0] prod_b_reg,    prod_b_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_r_reg,     out_r_next;
    logic [7:0]  out_g_reg,     out_g_next;
    logic [7:0]  out_b_reg,     out_b_next;
    logic        out_lit_reg,   out_lit_next;

    logic        out_free;
    logic        start;
    logic [8:0]  level_up;
    logic [8:0]  bottom;

    assign out_valid   = out_valid_reg;
    assign red_drive   = out_r_reg;
    assign green_drive = out_g_reg;
    assign blue_drive  = out_b_reg;
    assign lit         = out_lit_reg;

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        rising_next    = rising_reg;
        active_next    = active_reg;
        hold_left_next = hold_left_reg;
        hold_len_next  = hold_len_reg;
        col_r_next     = col_r_reg;
        col_g_next     = col_g_reg;
        col_b_next     = col_b_reg;
        sq_next        = sq_reg;
        prod_r_next    = prod_r_reg;
        prod_g_next    = prod_g_reg;
        prod_b_next    = prod_b_reg;
        out_valid_next = out_valid_reg;
        out_r_next     = out_r_reg;
        out_g_next     = out_g_reg;
        out_b_next     = out_b_reg;
        out_lit_next   = out_lit_reg;
        cmd_pop        = 1'b0;
        start          = 1'b0;

        out_free = !out_valid_reg || out_ready;
        level_up = {1'b0, level_reg} + {1'b0, step_reg};
        bottom   = {1'b0, min_reg} + {1'b0, step_reg};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_NOTIFY:
                        begin
                            cmd_pop = 1'b1;
                            start   = 1'b1;
                        end
                        OP_WEAK:
                        begin
                            cmd_pop = 1'b1;
                            start   = !active_reg;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop = 1'b1;
                                if (!active_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_r_next     = 8'd0;
                                    out_g_next     = 8'd0;
                                    out_b_next     = 8'd0;
                                    out_lit_next   = 1'b0;
                                end
                                else if (hold_left_reg != 8'd0)
                                begin
                                    hold_left_next = hold_left_reg - 8'd1;
                                    state_next     = ST_SQUARE;
                                end
                                else if (rising_reg)
                                begin
                                    if (level_up >= {1'b0, max_reg})
                                    begin
                                        rising_next    = 1'b0;
                                        hold_left_next = hold_len_reg;
                                    end
                                    else
                                    begin
                                        level_next = level_up[7:0];
                                    end
                                    state_next = ST_SQUARE;
                                end
                                else if ({1'b0, level_reg} <= bottom)
                                begin
                                    // The tick that ends the envelope shows a dark LED.
                                    active_next    = 1'b0;
                                    out_valid_next = 1'b1;
                                    out_r_next     = 8'd0;
                                    out_g_next     = 8'd0;
                                    out_b_next     = 8'd0;
                                    out_lit_next   = 1'b0;
                                end
                                else
                                begin
                                    level_next = level_reg - step_reg;
                                    state_next = ST_SQUARE;
                                end
                            end
                        end
                    endcase
                end
            end
            ST_SQUARE:
            begin
                sq_next    = {8'd0, level_reg} * {8'd0, level_reg};
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                prod_r_next = {16'd0, col_r_reg} * {8'd0, sq_reg};
                prod_g_next = {16'd0, col_g_reg} * {8'd0, sq_reg};
                prod_b_next = {16'd0, col_b_reg} * {8'd0, sq_reg};
                state_next  = ST_DRIVE;
            end
            ST_DRIVE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_r_next     = drive_from_product(prod_r_reg);
                    out_g_next     = drive_from_product(prod_g_reg);
                    out_b_next     = drive_from_product(prod_b_reg);
                    out_lit_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start)
        begin
            col_r_next     = cmd.red;
            col_g_next     = cmd.green;
            col_b_next     = cmd.blue;
            hold_len_next  = cmd.hold;
            rising_next    = 1'b1;
            active_next    = 1'b1;
            level_next     = min_reg;
            hold_left_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= MAX_RESET;
            min_reg       <= MIN_RESET;
            step_reg      <= STEP_RESET;
            state_reg     <= ST_IDLE;
            level_reg     <= 8'd0;
            rising_reg    <= 1'b1;
            active_reg    <= 1'b0;
            hold_left_reg <= 8'd0;
            hold_len_reg  <= DEFAULT_HOLD;
            col_r_reg     <= 8'd0;
            col_g_reg     <= 8'd0;
            col_b_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX:  max_reg  <= cfg_data;
                    REG_MIN:  min_reg  <= cfg_data;
                    REG_STEP: step_reg <= cfg_data;
                    default:  ;
                endcase
            end
            state_reg     <= state_next;
            level_reg     <= level_next;
            rising_reg    <= rising_next;
            active_reg    <= active_next;
            hold_left_reg <= hold_left_next;
            hold_len_reg  <= hold_len_next;
            col_r_reg     <= col_r_next;
            col_g_reg     <= col_g_next;
            col_b_reg     <= col_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg      <= sq_next;
        prod_r_reg  <= prod_r_next;
        prod_g_reg  <= prod_g_next;
        prod_b_reg  <= prod_b_next;
        out_r_reg   <= out_r_next;
        out_g_reg   <= out_g_next;
        out_b_reg   <= out_b_next;
        out_lit_reg <= out_lit_next;
    end

endmodule

>>> design/led_nfe_checker.sv
// Port-level checker for the LED fade envelope block, bound to the top level.
// Uses the assertion macros of led_notify_fade_envelope_defines.svh.
`include "led_notify_fade_envelope_defines.svh"

module led_nfe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    `LNFE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `LNFE_ASSERT_SAME(a_dark_zero, m_axis_tvalid && !m_axis_tdata[24], m_axis_tdata[23:0] == 24'd0)
    `LNFE_ASSERT_SAME(a_pad_zero, m_axis_tvalid, m_axis_tdata[31:25] == 7'd0)

endmodule

bind led_notify_fade_envelope led_nfe_checker u_led_nfe_checker (.*);

>>> dv/led_envelope_checker.sv
`timescale 1ns / 100ps
// Checker for the LED fade envelope block: it follows the request and drive streams
// and the register writes, predicts each drive result and compares it on arrival.
// Depends on led_nfe_pkg for the request and register codes and the reset values.
module led_envelope_checker
    import led_nfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output int unsigned mismatches,
    output int unsigned pending
);

    typedef struct packed {
        logic       lit;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } drive_t;

    logic [7:0] top_level;
    logic [7:0] base_level;
    logic [7:0] ramp_step;

    logic [7:0] level;
    logic       rising;
    logic       active;
    logic [7:0] hold_left;
    logic [7:0] hold_length;
    logic [7:0] colour_r;
    logic [7:0] colour_g;
    logic [7:0] colour_b;

    drive_t expected_drives[$];

    function automatic logic [7:0] scale_colour(input logic [7:0] colour, input logic [7:0] lvl);
        int unsigned product;
        int unsigned quotient;
        begin
            product = 32'(colour);
            product = product * lvl * lvl;
            quotient = product / 255;
            return (quotient > 255) ? 8'd255 : quotient[7:0];
        end
    endfunction

    task automatic start_envelope(input logic [39:0] data);
        colour_r = data[7:0];
        colour_g = data[15:8];
        colour_b = data[23:16];
        rising = 1'b1;
        active = 1'b1;
        level = base_level;
        hold_left = 8'd0;
        hold_length = data[32] ? data[31:24] : DEFAULT_HOLD;
    endtask

    task automatic advance_envelope();
        drive_t drive;
        int     threshold;
        logic   dark;
        begin
            drive = '0;
            dark = !active;
            if (active)
            begin
                if (hold_left != 8'd0)
                begin
                    hold_left = hold_left - 8'd1;
                end
                else if (rising)
                begin
                    threshold = int'(top_level);
                    threshold = threshold - int'(ramp_step);
                    if (int'(level) >= threshold)
                    begin
                        rising = 1'b0;
                        hold_left = hold_length;
                    end
                    else
                    begin
                        level = level + ramp_step;
                    end
                end
                else
                begin
                    threshold = int'(base_level);
                    threshold = threshold + int'(ramp_step);
                    if (int'(level) <= threshold)
                    begin
                        active = 1'b0;
                        dark = 1'b1;
                    end
                    else
                    begin
                        level = level - ramp_step;
                    end
                end
            end
            if (!dark)
            begin
                drive.red = scale_colour(colour_r, level);
                drive.green = scale_colour(colour_g, level);
                drive.blue = scale_colour(colour_b, level);
                drive.lit = 1'b1;
            end
            expected_drives.push_back(drive);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_t got;
        drive_t want;
        if (!rst_n)
        begin
            top_level = MAX_RESET;
            base_level = MIN_RESET;
            ramp_step = STEP_RESET;
            level = 8'd0;
            rising = 1'b1;
            active = 1'b0;
            hold_left = 8'd0;
            hold_length = DEFAULT_HOLD;
            colour_r = 8'd0;
            colour_g = 8'd0;
            colour_b = 8'd0;
            expected_drives.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[24:0];
                if (expected_drives.size() == 0)
                begin
                    $display("%0t: unexpected drive result r=%0d g=%0d b=%0d lit=%0d",
                             $time, got.red, got.green, got.blue, got.lit);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    if (got !== want)
                    begin
                        $display({"%0t: drive mismatch, expected r=%0d g=%0d b=%0d lit=%0d,",
                                  " got r=%0d g=%0d b=%0d lit=%0d"},
                                 $time, want.red, want.green, want.blue, want.lit,
                                 got.red, got.green, got.blue, got.lit);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MAX:  top_level = cfg_data;
                    REG_MIN:  base_level = cfg_data;
                    REG_STEP: ramp_step = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    OP_TICK:   advance_envelope();
                    OP_NOTIFY: start_envelope(s_axis_tdata);
                    OP_WEAK:
                    begin
                        if (!active)
                        begin
                            start_envelope(s_axis_tdata);
                        end
                    end
                    default: ;
                endcase
            end
        end
        pending = expected_drives.size();
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Top of the LED fade envelope testbench: clock, reset, request and register stimulus,
// random back-pressure and the verdict. Depends on led_nfe_pkg, the block and the checker.
module testbench;
    import led_nfe_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS = 172;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // red, green, blue, hold_ticks, hold_given, zero pad
    logic [1:0]  s_axis_tuser = '0;   // operation
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // red_drive, green_drive, blue_drive, lit, zero pad
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    int unsigned mismatches;
    int unsigned pending;
    int          idle_cycles = 0;
    int          rx_stall = 0;
    bit          rx_burst = 1'b0;
    bit          tx_burst = 1'b0;

    led_notify_fade_envelope dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    led_envelope_checker envelope_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                return 0;
            end
            if (roll < 85)
            begin
                return $urandom_range(1, 3);
            end
            if (roll < 97)
            begin
                return $urandom_range(4, 12);
            end
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [39:0] pack_request(input logic [7:0] red, input logic [7:0] green,
                                                 input logic [7:0] blue, input logic [7:0] hold,
                                                 input logic given);
        return {7'd0, given, hold, blue, green, red};
    endfunction

    function automatic logic [7:0] random_colour();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 15)
            begin
                return 8'd0;
            end
            if (roll < 30)
            begin
                return 8'd255;
            end
            return 8'($urandom_range(0, 255));
        end
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [39:0] data);
        int gap;
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= data;
            s_axis_tuser <= op;
            @(posedge clk);
            while (!s_axis_tready)
            begin
                @(posedge clk);
            end
            if ($urandom_range(0, 39) == 0)
            begin
                tx_burst = !tx_burst;
            end
            gap = tx_burst ? 0 : pick_gap();
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_envelope_cfg(input logic [7:0] top, input logic [7:0] base,
                                      input logic [7:0] step);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_index <= REG_MAX;
        cfg_data <= top;
        @(posedge clk);
        cfg_index <= REG_MIN;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= REG_STEP;
        cfg_data <= step;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int         roll;
        logic [1:0] op;
        logic [7:0] hold;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 78)
            begin
                op = OP_TICK;
            end
            else if (roll < 88)
            begin
                op = OP_NOTIFY;
            end
            else if (roll < 97)
            begin
                op = OP_WEAK;
            end
            else
            begin
                op = OP_UNUSED;
            end
            hold = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6))
                                              : 8'($urandom_range(0, 255));
            send_request(op, pack_request(random_colour(), random_colour(), random_colour(),
                                          hold, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic run_phase(input logic [7:0] top, input logic [7:0] base,
                             input logic [7:0] step);
        write_envelope_cfg(top, base, step);
        repeat (PHASE_ITEMS) random_request();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_stall = 0;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
            begin
                rx_burst = !rx_burst;
            end
            if (rx_stall > 0)
            begin
                rx_stall = rx_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!rx_burst && $urandom_range(0, 3) == 0)
            begin
                rx_stall = pick_gap();
                m_axis_tready <= (rx_stall == 0);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_TICK, pack_request(8'd0, 8'd0, 8'd0, 8'd0, 1'b0));
        send_request(OP_UNUSED, pack_request(8'd255, 8'd255, 8'd255, 8'd255, 1'b1));
        send_request(OP_NOTIFY, pack_request(8'd255, 8'd0, 8'd128, 8'd0, 1'b0));
        send_request(OP_WEAK, pack_request(8'd1, 8'd2, 8'd3, 8'd9, 1'b1));
        repeat (12) send_request(OP_TICK, 40'($urandom));
        send_request(OP_WEAK, pack_request(8'd255, 8'd255, 8'd255, 8'd0, 1'b1));
        repeat (9) send_request(OP_TICK, 40'($urandom));

        run_phase(8'd10, 8'd0, 8'd2);
        run_phase(8'd255, 8'd0, 8'd1);
        run_phase(8'd0, 8'd255, 8'd255);
        run_phase(8'd200, 8'd50, 8'd7);
        run_phase(8'd255, 8'd255, 8'd0);
        run_phase(8'd40, 8'd3, 8'd0);
        run_phase(8'd255, 8'd0, 8'd255);
        run_phase(8'd128, 8'd17, 8'd13);

        wait_drained();
        if (mismatches == 0)
        begin
            $display("testbench: PASS");
        end
        else
        begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/led_nfe_pkg.sv
design/led_nfe_front.sv
design/led_nfe_back.sv
design/led_notify_fade_envelope.sv
design/led_nfe_checker.sv
dv/led_envelope_checker.sv
dv/testbench.sv
